// ===== rtl/yfd_pkg.sv =====
// Package for the Y86-64 instruction fetch and decode unit.
// It holds the item types, status codes, opcode constants and decode helpers.
// It depends on nothing.
package yfd_pkg;

  // Consecutive halts that are still reported as shown.
  localparam int HALT_SHOW_LIMIT = 5;
  localparam int HALT_RUN_W      = $clog2(HALT_SHOW_LIMIT + 2);

  localparam logic [HALT_RUN_W-1:0] HALT_RUN_MAX = HALT_RUN_W'(HALT_SHOW_LIMIT + 1);
  localparam logic [HALT_RUN_W-1:0] HALT_RUN_LIM = HALT_RUN_W'(HALT_SHOW_LIMIT);

  typedef logic [2:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_BAD_OP  = 3'd1;
  localparam status_t ST_BAD_FUN = 3'd2;
  localparam status_t ST_MEM     = 3'd3;
  localparam status_t ST_END     = 3'd4;

  // Opcodes that the decoder treats specially.
  localparam logic [3:0] IC_HALT  = 4'h0;
  localparam logic [3:0] IC_CMOV  = 4'h2;
  localparam logic [3:0] IC_JXX   = 4'h7;
  localparam logic [3:0] IC_OPQ   = 4'h6;

  // Instruction lengths in bytes.
  localparam logic [3:0] LEN_NONE  = 4'd0;
  localparam logic [3:0] LEN_ONE   = 4'd1;
  localparam logic [3:0] LEN_REGS  = 4'd2;
  localparam logic [3:0] LEN_CONST = 4'd9;
  localparam logic [3:0] LEN_FULL  = 4'd10;
  localparam logic [3:0] CONST_BYTES = 4'd8;

  localparam logic [3:0] MAX_FUN = 4'd6;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] instr_pc;
    logic [3:0]  op_code;
    logic [3:0]  func_code;
    logic        regs_valid;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic        const_valid;
    logic [63:0] const_value;
    logic [63:0] next_pc;
    status_t     status;
    logic        shown;
    logic [3:0]  bytes_read;
  } out_item_t;

  // Instruction length from icode; zero marks an invalid opcode.
  function automatic logic [3:0] len_of_icode(input logic [3:0] icode);
    logic [3:0] len;
    unique case (icode)
      4'h0, 4'h1, 4'h9:       len = LEN_ONE;
      4'h2, 4'h6, 4'hA, 4'hB: len = LEN_REGS;
      4'h3, 4'h4, 4'h5:       len = LEN_FULL;
      4'h7, 4'h8:             len = LEN_CONST;
      default:                len = LEN_NONE;
    endcase
    return len;
  endfunction

  // Conditional moves, ALU ops and jumps take function codes up to six.
  function automatic logic fun_ok(input logic [3:0] icode, input logic [3:0] ifun);
    logic ok;
    if (icode == IC_CMOV || icode == IC_OPQ || icode == IC_JXX) begin
      ok = (ifun <= MAX_FUN);
    end else begin
      ok = (ifun == 4'd0);
    end
    return ok;
  endfunction

  function automatic logic has_regs(input logic [3:0] len);
    return (len == LEN_REGS) || (len == LEN_FULL);
  endfunction

endpackage

// ===== rtl/yfd_if.sv =====
// Valid/ready channel interfaces for the fetch and decode unit.
// Depends on yfd_pkg for the item types.
interface yfd_in_if;
  import yfd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface yfd_out_if;
  import yfd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/y86_instruction_fetch_decode_unit.sv =====
// Y86-64 instruction fetch and decode: assembles instructions byte by byte.
// A result is registered into the output register as its last byte is accepted.
// Throughput: one byte per cycle while the output register can load; the fetch registers update at each accept.
// A result that waits in the output register holds off input until it is taken.
// Reset (synchronous, rst_n low) clears the PC to zero, the fetch state,
// the halt run and the stop flag; the output register comes up empty.
module y86_instruction_fetch_decode_unit (
  input  logic         clk,
  input  logic         rst_n,
  yfd_in_if.sink       in_ch,
  yfd_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata
);
  import yfd_pkg::*;

  logic [63:0]           fetch_pc_r, fetch_pc_nxt;
  logic [3:0]            byte_index_r, byte_index_nxt;
  logic [3:0]            instr_length_r, instr_length_nxt;
  logic [7:0]            first_byte_r, first_byte_nxt;
  logic [7:0]            reg_byte_r, reg_byte_nxt;
  logic [63:0]           const_accum_r, const_accum_nxt;
  logic [HALT_RUN_W-1:0] halt_run_r, halt_run_nxt;
  logic                  stopped_r, stopped_nxt;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      res_valid;
  out_item_t res;
  logic      load_out;
  logic      accept;

  // The output register takes a new result whenever it is empty or being drained.
  assign load_out    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = load_out;
  assign accept      = in_ch.valid && load_out;

  // Fetch state update and result formation for one accepted item.
  always_comb begin
    logic [3:0] cur_len;
    logic [7:0] cur_first;
    logic [3:0] dec_len;
    logic [2:0] sh;
    logic       done;
    logic       shown;

    fetch_pc_nxt     = fetch_pc_r;
    byte_index_nxt   = byte_index_r;
    instr_length_nxt = instr_length_r;
    first_byte_nxt   = first_byte_r;
    reg_byte_nxt     = reg_byte_r;
    const_accum_nxt  = const_accum_r;
    halt_run_nxt     = halt_run_r;
    stopped_nxt      = stopped_r;
    res_valid        = 1'b0;
    res              = '0;
    cur_len          = instr_length_r;
    cur_first        = first_byte_r;
    dec_len          = len_of_icode(in_ch.data.byte_value[7:4]);
    sh               = 3'(byte_index_r - (instr_length_r - CONST_BYTES));
    done             = 1'b0;
    shown            = 1'b1;

    if (accept && !stopped_r) begin
      if (in_ch.data.cmd) begin
        // End of memory: clean at a boundary, an error inside an instruction.
        res_valid    = 1'b1;
        res.instr_pc = fetch_pc_r;
        res.shown    = 1'b1;
        stopped_nxt  = 1'b1;
        if (byte_index_r == 4'd0) begin
          res.status = ST_END;
        end else begin
          res.status     = ST_MEM;
          res.op_code    = first_byte_r[7:4];
          res.func_code  = first_byte_r[3:0];
          res.bytes_read = byte_index_r;
        end
      end else if (byte_index_r == 4'd0) begin
        // First byte: decode and check opcode and function.
        first_byte_nxt = in_ch.data.byte_value;
        cur_first      = in_ch.data.byte_value;
        if (dec_len == LEN_NONE ||
            !fun_ok(in_ch.data.byte_value[7:4], in_ch.data.byte_value[3:0])) begin
          res_valid      = 1'b1;
          res.instr_pc   = fetch_pc_r;
          res.op_code    = in_ch.data.byte_value[7:4];
          res.func_code  = in_ch.data.byte_value[3:0];
          res.status     = (dec_len == LEN_NONE) ? ST_BAD_OP : ST_BAD_FUN;
          res.shown      = 1'b1;
          res.bytes_read = 4'd1;
          stopped_nxt    = 1'b1;
        end else begin
          instr_length_nxt = dec_len;
          cur_len          = dec_len;
          reg_byte_nxt     = '0;
          const_accum_nxt  = '0;
          byte_index_nxt   = 4'd1;
          done             = (dec_len == LEN_ONE);
        end
      end else begin
        // Later bytes: register specifier, then the little-endian constant.
        if (has_regs(instr_length_r) && byte_index_r == 4'd1) begin
          reg_byte_nxt = in_ch.data.byte_value;
        end else if (instr_length_r >= LEN_CONST &&
                     byte_index_r >= (instr_length_r - CONST_BYTES)) begin
          const_accum_nxt = const_accum_r |
                            ({56'd0, in_ch.data.byte_value} << {sh, 3'b000});
        end
        byte_index_nxt = byte_index_r + 4'd1;
        done           = (byte_index_nxt == instr_length_r);
      end

      // A completed instruction reports its fields and moves the PC on.
      if (done) begin
        if (cur_first[7:4] == IC_HALT) begin
          if (halt_run_r < HALT_RUN_MAX) begin
            halt_run_nxt = halt_run_r + HALT_RUN_W'(1);
          end
          shown = (halt_run_nxt <= HALT_RUN_LIM);
        end else begin
          halt_run_nxt = '0;
        end
        res_valid     = 1'b1;
        res.instr_pc  = fetch_pc_r;
        res.op_code   = cur_first[7:4];
        res.func_code = cur_first[3:0];
        if (has_regs(cur_len)) begin
          res.regs_valid = 1'b1;
          res.reg_a      = reg_byte_nxt[7:4];
          res.reg_b      = reg_byte_nxt[3:0];
        end
        if (cur_len >= LEN_CONST) begin
          res.const_valid = 1'b1;
          res.const_value = const_accum_nxt;
        end
        res.next_pc    = fetch_pc_r + {60'd0, cur_len};
        res.status     = ST_OK;
        res.shown      = shown;
        res.bytes_read = cur_len;
        fetch_pc_nxt   = fetch_pc_r + {60'd0, cur_len};
        byte_index_nxt = 4'd0;
      end
    end

    // A configuration write loads the program counter directly.
    if (cfg_we) begin
      fetch_pc_nxt = cfg_wdata;
    end
  end

  // Fetch state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_pc_r     <= '0;
      byte_index_r   <= '0;
      instr_length_r <= '0;
      first_byte_r   <= '0;
      reg_byte_r     <= '0;
      const_accum_r  <= '0;
      halt_run_r     <= '0;
      stopped_r      <= 1'b0;
    end else begin
      fetch_pc_r     <= fetch_pc_nxt;
      byte_index_r   <= byte_index_nxt;
      instr_length_r <= instr_length_nxt;
      first_byte_r   <= first_byte_nxt;
      reg_byte_r     <= reg_byte_nxt;
      const_accum_r  <= const_accum_nxt;
      halt_run_r     <= halt_run_nxt;
      stopped_r      <= stopped_nxt;
    end
  end

  // Output register: valid is control, the item itself carries no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== rtl/yfd_checker.sv =====
// Port-level checks for the fetch and decode unit, bound to the top level.
// Depends on yfd_pkg for the result item type and status codes.
module yfd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input yfd_pkg::out_item_t out_data
);
  import yfd_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An offered item is taken whenever the output register is empty.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // After a status result is taken, the block stays silent.
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.status != ST_OK |=> !out_valid)
    else $error("result after a status report");

  // A good instruction reports valP as its address plus its length.
  a_valp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |->
      out_data.next_pc == out_data.instr_pc + {60'd0, out_data.bytes_read})
    else $error("next_pc does not match instruction length");

  // Only a good halt may be hidden.
  a_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.shown |->
      out_data.status == ST_OK && out_data.op_code == IC_HALT)
    else $error("hidden result that is not a halt");

endmodule

bind y86_instruction_fetch_decode_unit yfd_checker u_yfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
